// File: hw/rtl/tga_rle_pixel_decoder_defines.svh
// Assertion macros shared by the checkers of the TGA RLE pixel decoder.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define TRLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define TRLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/trle_pkg.sv
// Shared types, constants and helpers of the TGA RLE pixel decoder.
// No dependencies; used by trle_regs, trle_core and the top level.
package trle_pkg;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_BPP   = 1'b0;
	localparam logic REG_TOTAL = 1'b1;

	localparam logic [2:0]  BPP_RESET   = 3'd4;
	localparam logic [31:0] TOTAL_RESET = 32'd1;

	// packet header fields
	localparam int unsigned HDR_RUN_BIT    = 7;
	localparam logic [7:0]  HDR_COUNT_MASK = 8'h7f;

	// effective configuration as seen by the decoding datapath
	typedef struct packed {
		logic [1:0]  bpp_m1;  // bytes per pixel minus one, clamped to 1..4
		logic [31:0] total;   // pixels per image, zero treated as one
	} cfg_t;

	function automatic logic [1:0] bpp_m1_f(input logic [2:0] bpp);
		logic [1:0] r;
		unique case (bpp)
			3'd0, 3'd1: r = 2'd0;
			3'd2:       r = 2'd1;
			3'd3:       r = 2'd2;
			default:    r = 2'd3;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] total_f(input logic [31:0] total);
		return (total == 32'd0) ? 32'd1 : total;
	endfunction

endpackage

// File: hw/rtl/trle_regs.sv
// APB register file of the TGA RLE pixel decoder: pixel width and image size.
// Depends on trle_pkg.
module trle_regs import trle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [2:0]  bpp_q;
	logic [31:0] total_q;
	logic        wr_en;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q   <= BPP_RESET;
			total_q <= TOTAL_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_BPP:   bpp_q   <= pwdata[2:0];
				REG_TOTAL: total_q <= pwdata[31:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_BPP:   prdata = {29'd0, bpp_q};
			REG_TOTAL: prdata = total_q;
			default:   prdata = '0;
		endcase
	end

	assign cfg.bpp_m1 = bpp_m1_f(bpp_q);
	assign cfg.total  = total_f(total_q);

endmodule

// File: hw/rtl/trle_core.sv
// Packet parser and pixel assembler: input register, decode state, result register.
// Depends on trle_pkg for the configuration struct and header constants.
module trle_core import trle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  in_byte,
	output logic        pixel_valid,
	input  logic        pixel_stall,
	output logic [31:0] pixel_value,
	output logic [7:0]  repeat_count,
	output logic        image_end
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	logic        expect_header_q;
	logic        run_q;
	logic [7:0]  left_q;
	logic [1:0]  idx_q;
	logic [31:0] acc_q;
	logic [31:0] done_q;

	logic        pixel_valid_q;
	logic [31:0] pixel_value_q;
	logic [7:0]  repeat_count_q;
	logic        image_end_q;

	logic [31:0] acc_next;
	logic        pixel_done;
	logic [7:0]  count_raw;
	logic [7:0]  count;
	logic [32:0] diff;
	logic [31:0] remaining;
	logic        last;
	logic [7:0]  count_out;
	logic [7:0]  left_after;

	// hold the input register while the result register is full and stalled
	assign advance    = valid_s1 && (!pixel_valid_q || !pixel_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		acc_next   = acc_q | ({24'd0, byte_s1} << {idx_q, 3'b000});
		pixel_done = !expect_header_q && (idx_q >= cfg.bpp_m1);
		count_raw  = run_q ? left_q : 8'd1;
		count      = (count_raw == 8'd0) ? 8'd1 : count_raw;
		diff       = {1'b0, cfg.total} - {1'b0, done_q};
		// total at or below pixels done: treat as one pixel left
		remaining  = (diff[32] || (diff[31:0] == 32'd0)) ? 32'd1 : diff[31:0];
		last       = (remaining[31:8] == 24'd0) && (remaining[7:0] <= count);
		count_out  = last ? remaining[7:0] : count;
		left_after = run_q ? 8'd0 : left_q - 8'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			run_q           <= 1'b0;
			left_q          <= 8'd0;
			idx_q           <= 2'd0;
			acc_q           <= 32'd0;
			done_q          <= 32'd0;
		end else if (advance) begin
			if (expect_header_q) begin
				run_q           <= byte_s1[HDR_RUN_BIT];
				left_q          <= (byte_s1 & HDR_COUNT_MASK) + 8'd1;
				idx_q           <= 2'd0;
				acc_q           <= 32'd0;
				expect_header_q <= 1'b0;
			end else if (!pixel_done) begin
				acc_q <= acc_next;
				idx_q <= idx_q + 2'd1;
			end else begin
				acc_q <= 32'd0;
				idx_q <= 2'd0;
				if (last) begin
					// rearm for the next image, drop what is left of the packet
					expect_header_q <= 1'b1;
					run_q           <= 1'b0;
					left_q          <= 8'd0;
					done_q          <= 32'd0;
				end else begin
					done_q <= done_q + {24'd0, count_out};
					left_q <= left_after;
					if (left_after == 8'd0) begin
						expect_header_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid_q <= 1'b0;
		end else if (advance) begin
			pixel_valid_q <= pixel_done;
		end else if (!pixel_stall) begin
			pixel_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pixel_done) begin
			pixel_value_q  <= acc_next;
			repeat_count_q <= count_out;
			image_end_q    <= last;
		end
	end

	assign pixel_valid  = pixel_valid_q;
	assign pixel_value  = pixel_value_q;
	assign repeat_count = repeat_count_q;
	assign image_end    = image_end_q;

endmodule

// File: hw/rtl/tga_rle_pixel_decoder.sv
// TGA RLE pixel decoder top level: APB registers plus the decoding pipeline.
// A byte is taken into the input register, decoded, and its pixel held in the result register.
// Throughput: one byte per cycle while the output is not stalled, set by the single decode step
// between the input register and the result register; a run of up to 128 pixels leaves as one request.
// Reset (arst_n low, asynchronous): awaits a packet header, pixel count zero,
// bytes_per_pixel 4, total_pixels 1. Depends on trle_pkg, trle_regs, trle_core.
module tga_rle_pixel_decoder import trle_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  logic [7:0]            in_byte,
	output logic                  pixel_valid,
	input  logic                  pixel_stall,
	output logic [31:0]           pixel_value,
	output logic [7:0]            repeat_count,
	output logic                  image_end
);

	cfg_t cfg;

	trle_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	trle_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.in_byte      (in_byte),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.image_end    (image_end)
	);

endmodule

// File: hw/rtl/trle_checker.sv
// Port-level checker of the TGA RLE pixel decoder, bound to the top level.
// Depends on tga_rle_pixel_decoder_defines.svh.
`include "tga_rle_pixel_decoder_defines.svh"

module trle_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  pready,
	input logic                  byte_valid,
	input logic                  byte_stall,
	input logic                  pixel_valid,
	input logic                  pixel_stall,
	input logic [31:0]           pixel_value,
	input logic [7:0]            repeat_count,
	input logic                  image_end
);

	`TRLE_ASSERT(a_pready_high, pready, "pready dropped")

	`TRLE_ASSERT(a_count_range, !pixel_valid || ((repeat_count != 8'd0) && (repeat_count <= 8'd128)), "repeat_count out of range")

	`TRLE_ASSERT_NEXT(a_out_hold, pixel_valid && pixel_stall, pixel_valid && $stable(pixel_value) && $stable(repeat_count) && $stable(image_end), "stalled pixel request changed")

	// a fresh result comes from a byte taken earlier through the input register
	`TRLE_ASSERT(a_out_latency, !$rose(pixel_valid) || $past(byte_valid && !byte_stall, 2), "pixel request without a matching byte")

endmodule

bind tga_rle_pixel_decoder trle_checker u_trle_checker (.*);

// File: test/tga_rle_pixel_decoder_tb.sv
// Self-checking bench for tga_rle_pixel_decoder: directed packet table, then random
// packet streams under random stalls, checked against an in-bench decoder model.
// Depends on trle_pkg and the tga_rle_pixel_decoder RTL only.
module tga_rle_pixel_decoder_tb import trle_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_BYTES = 1900;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned LONG_HOLD    = 250;
	localparam int unsigned QUIET_FROM   = 1650;
	localparam int unsigned HOLD_FROM    = 700;

	typedef struct packed {
		logic [31:0] value;
		logic [7:0]  count;
		logic        last;
	} pixel_t;

	typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic        idx;
		logic [31:0] data;
		logic        typed;
		pixel_t      px;
	} dir_row_t;

	localparam pixel_t NO_PX = '0;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  byte_valid, byte_stall;
	logic [7:0]            in_byte;
	logic                  pixel_valid, pixel_stall;
	logic [31:0]           pixel_value;
	logic [7:0]            repeat_count;
	logic                  image_end;

	tga_rle_pixel_decoder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.in_byte      (in_byte),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_value  (pixel_value),
		.repeat_count (repeat_count),
		.image_end    (image_end)
	);

	always #6 clk = ~clk;

	// directed packets: a typed row gives the pixel it completes, other rows leave it to the decoder model
	dir_row_t dir_tab [35] = '{
		'{ROW_BYTE,  REG_BPP,   32'h80,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'hff,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'hff,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'hff,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'hff,        1'b1, '{32'hffff_ffff, 8'd1, 1'b1}},
		'{ROW_WRITE, REG_BPP,   32'd0,         1'b0, NO_PX},
		'{ROW_WRITE, REG_TOTAL, 32'd0,         1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h7f,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h5a,        1'b1, '{32'h0000_005a, 8'd1, 1'b1}},
		'{ROW_WRITE, REG_TOTAL, 32'd300,       1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'hff,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h00,        1'b1, '{32'h0000_0000, 8'd128, 1'b0}},
		'{ROW_BYTE,  REG_BPP,   32'h00,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h3c,        1'b1, '{32'h0000_003c, 8'd1, 1'b0}},
		'{ROW_BYTE,  REG_BPP,   32'h81,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h01,        1'b1, '{32'h0000_0001, 8'd2, 1'b0}},
		'{ROW_WRITE, REG_BPP,   32'd7,         1'b0, NO_PX},
		'{ROW_WRITE, REG_TOTAL, 32'd1,         1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h85,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h11,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h22,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h33,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h44,        1'b1, '{32'h4433_2211, 8'd1, 1'b1}},
		'{ROW_WRITE, REG_BPP,   32'd2,         1'b0, NO_PX},
		'{ROW_WRITE, REG_TOTAL, 32'hfffe_0001, 1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h01,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'haa,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'hbb,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'hcc,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'hdd,        1'b0, NO_PX},
		'{ROW_WRITE, REG_BPP,   32'd3,         1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h82,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h01,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h02,        1'b0, NO_PX},
		'{ROW_BYTE,  REG_BPP,   32'h03,        1'b0, NO_PX}
	};

	// decoder model state and configuration
	logic [2:0]  cfg_bpp;
	logic [31:0] cfg_total;
	logic        want_header;
	logic        in_run;
	logic [7:0]  pixels_left;
	logic [1:0]  byte_idx;
	logic [31:0] pixel_acc;
	logic [31:0] image_pixels;

	pixel_t      pending_pixels[$];
	int unsigned errors = 0;
	int unsigned n_bytes = 0;
	int unsigned n_pixels = 0;
	int unsigned n_images = 0;
	int unsigned n_phases = 0;
	int unsigned n_full = 0;
	bit          quiet = 1'b0;
	bit          long_hold = 1'b0;

	task automatic flag_error(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	task automatic restart_image();
		want_header  = 1'b1;
		in_run       = 1'b0;
		pixels_left  = 8'd0;
		byte_idx     = 2'd0;
		pixel_acc    = 32'd0;
		image_pixels = 32'd0;
	endtask

	task automatic decode_byte(input logic [7:0] b, output bit has_px, output pixel_t px);
		int unsigned bpp;
		logic [31:0] total, remaining, count;
		bpp   = (cfg_bpp == 3'd0) ? 1 : (cfg_bpp > 3'd4) ? 4 : int'(cfg_bpp);
		total = (cfg_total == 32'd0) ? 32'd1 : cfg_total;
		has_px = 1'b0;
		px = '0;
		if (want_header) begin
			in_run      = b[HDR_RUN_BIT];
			pixels_left = (b & HDR_COUNT_MASK) + 8'd1;
			byte_idx    = 2'd0;
			pixel_acc   = 32'd0;
			want_header = 1'b0;
			return;
		end
		pixel_acc = pixel_acc | ({24'd0, b} << (8 * byte_idx));
		if (int'(byte_idx) + 1 < bpp) begin
			byte_idx = byte_idx + 2'd1;
			return;
		end
		remaining = (total > image_pixels) ? total - image_pixels : 32'd1;
		if (in_run) begin
			count       = {24'd0, pixels_left};
			pixels_left = 8'd0;
		end else begin
			count       = 32'd1;
			pixels_left = pixels_left - 8'd1;
		end
		if (count == 32'd0)
			count = 32'd1;
		if (count > remaining)
			count = remaining;
		has_px   = 1'b1;
		px.value = pixel_acc;
		px.count = count[7:0];
		px.last  = (count == remaining);
		byte_idx  = 2'd0;
		pixel_acc = 32'd0;
		if (px.last) begin
			restart_image();
		end else begin
			image_pixels = image_pixels + count;
			if (pixels_left == 8'd0)
				want_header = 1'b1;
		end
	endtask

	// offer one byte, hold it until accepted, then queue the pixel it completes
	task automatic send_byte(input logic [7:0] b, input logic typed, input pixel_t typed_px);
		bit     has_px;
		pixel_t px;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte    <= b;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		n_bytes++;
		decode_byte(b, has_px, px);
		if (typed)
			pending_pixels.push_back(typed_px);
		else if (has_px)
			pending_pixels.push_back(px);
	endtask

	// drop valid and let the pipeline empty before touching registers
	task automatic go_idle();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		logic [31:0] mask;
		mask = (idx == REG_BPP) ? 32'h0000_0007 : 32'hffff_ffff;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		// read back through a second transfer
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if ((prdata & mask) !== (val & mask))
			flag_error($sformatf("register %0d reads %h, wrote %h", idx, prdata, val));
		psel    <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_BPP)
			cfg_bpp = val[2:0];
		else
			cfg_total = val;
	endtask

	// pixel checker
	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (byte_valid === 1'b1 && byte_stall === 1'b1)
			n_full++;
		if (pixel_valid === 1'b1 && pixel_stall === 1'b0) begin
			if (pending_pixels.size() == 0) begin
				flag_error($sformatf("unexpected pixel %h x%0d end=%0b",
					pixel_value, repeat_count, image_end));
			end else begin
				want = pending_pixels.pop_front();
				n_pixels++;
				if (want.last)
					n_images++;
				if (pixel_value !== want.value)
					flag_error($sformatf("pixel_value %h, expected %h", pixel_value, want.value));
				if (repeat_count !== want.count)
					flag_error($sformatf("repeat_count %0d, expected %0d",
						repeat_count, want.count));
				if (image_end !== want.last)
					flag_error($sformatf("image_end %b, expected %b", image_end, want.last));
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request, none at the end
	initial begin : pixel_sink
		forever begin
			if (long_hold) begin
				pixel_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				pixel_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				pixel_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#(10_000_000);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		logic [7:0]  stream_q[$];
		logic [2:0]  new_bpp;
		logic [31:0] new_total;
		logic [6:0]  hdr_count;
		int unsigned eff_bpp, npix, cut;
		bit          run, hold_done;
		hold_done = 1'b0;
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		byte_valid <= 1'b0;
		in_byte    <= 8'd0;
		cfg_bpp   = BPP_RESET;
		cfg_total = TOTAL_RESET;
		restart_image();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_WRITE) begin
				go_idle();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
			end else begin
				send_byte(dir_tab[i].data[7:0], dir_tab[i].typed, dir_tab[i].px);
			end
		end

		while (n_bytes < RANDOM_BYTES + 35) begin
			go_idle();
			n_phases++;
			if (n_bytes >= QUIET_FROM)
				quiet = 1'b1;
			new_bpp = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(1, 4));
			case ($urandom_range(0, 9))
				0:       new_total = 32'd0;
				1:       new_total = 32'hfffe_0001;
				2:       new_total = $urandom();
				3, 4:    new_total = $urandom_range(1, 8);
				default: new_total = $urandom_range(9, 400);
			endcase
			cut = $urandom_range(1, 3);
			if (cut[0])
				write_reg(REG_BPP, {29'd0, new_bpp});
			if (cut[1])
				write_reg(REG_TOTAL, new_total);
			eff_bpp = (cfg_bpp == 3'd0) ? 1 : (cfg_bpp > 3'd4) ? 4 : int'(cfg_bpp);

			// well-formed packets with random content, some noise between them
			stream_q.delete();
			repeat ($urandom_range(2, 12)) begin
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					run = $urandom_range(0, 1);
					hdr_count = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
						: 7'($urandom_range(0, 15));
					stream_q.push_back({run, hdr_count});
					npix = run ? 1 : int'(hdr_count) + 1;
					repeat (npix * eff_bpp) stream_q.push_back(8'($urandom_range(0, 255)));
				end
			end
			// cut the phase short so the next register write lands mid-packet
			if ($urandom_range(0, 3) == 0 && stream_q.size() > 1) begin
				cut = $urandom_range(1, (stream_q.size() > 3) ? 3 : stream_q.size() - 1);
				repeat (cut) void'(stream_q.pop_back());
			end

			if (!hold_done && n_bytes >= HOLD_FROM) begin
				long_hold = 1'b1;
				hold_done = 1'b1;
			end
			foreach (stream_q[i])
				send_byte(stream_q[i], 1'b0, NO_PX);
		end

		go_idle();
		$display("Sent %0d bytes in %0d random phases after the directed table.",
			n_bytes, n_phases);
		$display("Checked %0d pixels, %0d image ends; input stalled for %0d cycles.",
			n_pixels, n_images, n_full);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
